FILE: rtl/acsp_pkg.sv
// Shared types, widths and arithmetic helpers for the box/shape pair tester.
// No dependencies; imported by every module of the block but acsp_fifo.
`default_nettype none

package acsp_pkg;

    localparam int DW          = 35;   // center deltas
    localparam int OW          = 38;   // overlaps and projections
    localparam int AXIS_SHIFT  = 14;   // Q1.14 axes
    localparam int SQ_STAGES   = 32;
    localparam int DIV_STAGES  = 15;
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        MODE_BOX    = 2'd0,
        MODE_CIRCLE = 2'd1,
        MODE_TRI    = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic [30:0]        a_half_w;
        logic [30:0]        a_half_h;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_size_x;
        logic signed [31:0] b_size_y;
        logic signed [15:0] hyp_axis_x;
        logic signed [15:0] hyp_axis_y;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
    } t_out;

    // front to back word
    typedef struct packed {
        logic [1:0]           mode;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] tdx;
        logic signed [DW-1:0] tdy;
        logic [30:0]          hw;
        logic [30:0]          hh;
        logic signed [31:0]   sx;
        logic signed [31:0]   sy;
        logic signed [15:0]   hx;
        logic signed [15:0]   hy;
    } t_mid;

    // back pipeline context, filled in stage by stage
    typedef struct packed {
        logic [1:0]           mode;
        logic                 hit0;
        logic                 third;
        logic                 hit;
        logic                 use3;
        logic                 negx;
        logic                 negy;
        logic signed [OW-1:0] ox;
        logic signed [OW-1:0] oy;
        logic signed [OW-1:0] bp;
        logic signed [OW-1:0] apbp;
        logic signed [OW-1:0] adist;
        logic signed [OW-1:0] ot;
        logic signed [OW-1:0] pxs;
        logic signed [OW-1:0] pys;
        logic signed [DW-1:0] dxs;
        logic signed [DW-1:0] dys;
        logic signed [DW-1:0] bdx;
        logic signed [DW-1:0] bdy;
        logic [30:0]          hw;
        logic [30:0]          hh;
        logic signed [31:0]   sx;
        logic signed [31:0]   sy;
        logic signed [15:0]   hx;
        logic signed [15:0]   hy;
        logic [30:0]          mx;
        logic [30:0]          my;
        logic signed [47:0]   pbx;
        logic signed [47:0]   pby;
        logic [61:0]          sqx;
        logic [61:0]          sqy;
        logic [63:0]          n;
        logic [33:0]          srem;
        logic [31:0]          mag;
        logic [45:0]          numx;
        logic [45:0]          numy;
        logic [14:0]          qx;
        logic [14:0]          qy;
        logic signed [15:0]   ux;
        logic signed [15:0]   uy;
        logic signed [50:0]   pdx;
        logic signed [50:0]   pdy;
        logic signed [47:0]   phw;
        logic signed [47:0]   phh;
        logic signed [51:0]   dsum;
        logic [33:0]          ahw;
        logic [33:0]          ahh;
        logic signed [53:0]   ptx;
        logic signed [53:0]   pty;
    } t_ctx;

    // signed divide by 2^14, truncating toward zero
    function automatic logic signed [63:0] f_tdiv14(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v < 0) ? v + ((64'sd1 <<< AXIS_SHIFT) - 64'sd1) : v;
        return t >>> AXIS_SHIFT;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/acsp_fifo.sv
// Queue with registered read data, used between front and back and on the result side.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module acsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt, n_cnt;
    logic             r_ov;
    logic             wr, pq, ld;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = ~r_ov;
    assign wr      = i_push & ~o_full;
    assign pq      = i_pop & r_ov;
    assign ld      = (r_cnt != '0) && (!r_ov || pq);
    assign n_cnt   = r_cnt + (AW+1)'(wr) - (AW+1)'(ld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + AW'(1);
            end
            if (ld) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= n_cnt;
            r_ov  <= ld | (r_ov & ~pq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
        if (ld) begin
            o_data <= r_mem[r_rp];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/acsp_front.sv
// Front stage: takes pair tests and forms the center deltas for the back end.
// Depends on acsp_pkg.
`default_nettype none

module acsp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  acsp_pkg::t_in i_item,
    input  logic          i_qfull,
    output logic          o_full,
    output logic          o_qpush,
    output acsp_pkg::t_mid o_qitem
);
    import acsp_pkg::*;

    logic r_fv, n_fv;
    logic acc;
    t_mid r_item, n_item;

    assign o_full  = r_fv & i_qfull;
    assign acc     = i_push & ~o_full;
    assign o_qpush = r_fv & ~i_qfull;
    assign o_qitem = r_item;
    assign n_fv    = acc | (r_fv & ~o_qpush);

    always_comb begin : form
        logic signed [DW-1:0] ax, ay, bx, by, sx, sy;
        ax = DW'(i_item.a_x);
        ay = DW'(i_item.a_y);
        bx = DW'(i_item.b_x);
        by = DW'(i_item.b_y);
        sx = DW'(i_item.b_size_x);
        sy = DW'(i_item.b_size_y);
        n_item.mode = i_item.mode;
        n_item.dx   = ax - bx;
        n_item.dy   = ay - by;
        n_item.tdx  = ax - (bx + sx);
        n_item.tdy  = ay - (by + sy);
        n_item.hw   = i_item.a_half_w;
        n_item.hh   = i_item.a_half_h;
        n_item.sx   = i_item.b_size_x;
        n_item.sy   = i_item.b_size_y;
        n_item.hx   = i_item.hyp_axis_x;
        n_item.hy   = i_item.hyp_axis_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/acsp_norm.sv
// Corner axis normalization: pipelined integer square root, then two
// pipelined restoring dividers for the rounded Q1.14 components. Depends on acsp_pkg.
`default_nettype none

module acsp_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  acsp_pkg::t_ctx i_ctx,
    output logic           o_valid,
    output acsp_pkg::t_ctx o_ctx
);
    import acsp_pkg::*;

    logic r_sv [SQ_STAGES];
    t_ctx r_sc [SQ_STAGES];
    logic r_pv;
    t_ctx r_pc;
    t_ctx n_prep;
    logic r_dv [DIV_STAGES];
    t_ctx r_dc [DIV_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
        logic pv;
        t_ctx pc, nc;
        if (k == 0) begin : g_in
            assign pv = i_valid;
            assign pc = i_ctx;
        end else begin : g_nx
            assign pv = r_sv[k-1];
            assign pc = r_sc[k-1];
        end

        always_comb begin : step
            logic [35:0] r2, tr;
            logic        ge;
            r2 = {pc.srem, pc.n[63-2*k -: 2]};
            tr = {2'b00, pc.mag, 2'b01};
            ge = (r2 >= tr);
            nc = pc;
            nc.srem = ge ? 34'(r2 - tr) : r2[33:0];
            nc.mag  = {pc.mag[30:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else begin
                r_sv[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sc[k] <= nc;
        end
    end

    // rounding numerators
    always_comb begin : prep
        t_ctx c;
        c = r_sc[SQ_STAGES-1];
        c.numx = 46'({c.mx, 14'b0}) + 46'(c.mag[31:1]);
        c.numy = 46'({c.my, 14'b0}) + 46'(c.mag[31:1]);
        c.qx   = '0;
        c.qy   = '0;
        n_prep = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= r_sv[SQ_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc <= n_prep;
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dv
        logic pv;
        t_ctx pc, nc;
        if (j == 0) begin : g_in
            assign pv = r_pv;
            assign pc = r_pc;
        end else begin : g_nx
            assign pv = r_dv[j-1];
            assign pc = r_dc[j-1];
        end

        always_comb begin : step
            logic [46:0] dd;
            logic        gx, gy;
            dd = 47'({pc.mag, 14'b0}) >> j;
            gx = ({1'b0, pc.numx} >= dd);
            gy = ({1'b0, pc.numy} >= dd);
            nc = pc;
            nc.numx = gx ? 46'({1'b0, pc.numx} - dd) : pc.numx;
            nc.numy = gy ? 46'({1'b0, pc.numy} - dd) : pc.numy;
            nc.qx   = {pc.qx[13:0], gx};
            nc.qy   = {pc.qy[13:0], gy};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else begin
                r_dv[j] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dc[j] <= nc;
        end
    end

    assign o_valid = r_dv[DIV_STAGES-1];
    assign o_ctx   = r_dc[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/acsp_back.sv
// Back end: overlaps on x and y, third axis projection, least-overlap push.
// Fixed-latency pipeline without stall. Depends on acsp_pkg and acsp_norm.
`default_nettype none

module acsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  acsp_pkg::t_mid i_item,
    output logic           o_valid,
    output acsp_pkg::t_out o_res
);
    import acsp_pkg::*;

    localparam int NB = 3;
    localparam int NP = 6;

    logic r_bv [NB];
    t_ctx r_bc [NB];
    t_ctx n_bc [NB];
    logic r_pv [NP];
    t_ctx r_pc [NP];
    t_ctx n_pc [NP];
    logic r_ov;
    t_out r_out, n_out;
    logic nrm_v;
    t_ctx nrm_c;

    // classify and overlaps on x and y
    always_comb begin : b0
        logic [DW-1:0]        adx, ady, atdx, atdy;
        logic [32:0]          asx, asy;
        logic signed [OW-1:0] hwo, hho, sxo, syo, ryo, adxo, adyo, atdxo, atdyo, asxo, asyo;
        logic signed [OW-1:0] ox, oy;
        logic signed [DW-1:0] dxs, dys;
        logic                 xa, ya, corner, hyp, halve;
        logic [31:0]          mx0, my0;
        t_ctx                 c;
        c     = '0;
        adx   = (i_item.dx < 0) ? -i_item.dx : i_item.dx;
        ady   = (i_item.dy < 0) ? -i_item.dy : i_item.dy;
        atdx  = (i_item.tdx < 0) ? -i_item.tdx : i_item.tdx;
        atdy  = (i_item.tdy < 0) ? -i_item.tdy : i_item.tdy;
        asx   = (i_item.sx < 0) ? -(33'(i_item.sx)) : 33'(i_item.sx);
        asy   = (i_item.sy < 0) ? -(33'(i_item.sy)) : 33'(i_item.sy);
        hwo   = OW'(i_item.hw);
        hho   = OW'(i_item.hh);
        sxo   = OW'(i_item.sx);
        syo   = OW'(i_item.sy);
        adxo  = OW'(adx);
        adyo  = OW'(ady);
        atdxo = OW'(atdx);
        atdyo = OW'(atdy);
        asxo  = OW'(asx);
        asyo  = OW'(asy);
        ryo   = (i_item.mode == MODE_BOX) ? syo : sxo;
        xa    = (i_item.sx > 0 && i_item.dx < 0) || (i_item.sx < 0 && i_item.dx > 0);
        ya    = (i_item.sy > 0 && i_item.dy < 0) || (i_item.sy < 0 && i_item.dy > 0);
        hyp   = ((i_item.dx > 0) != (i_item.sx < 0)) && ((i_item.dy > 0) != (i_item.sy < 0));
        corner = (i_item.mode == MODE_CIRCLE) && (adxo > hwo) && (adyo > hho);
        dxs   = i_item.dx;
        dys   = i_item.dy;
        unique case (i_item.mode)
            MODE_BOX, MODE_CIRCLE: begin
                ox = hwo + sxo - adxo;
                oy = hho + ryo - adyo;
            end
            MODE_TRI: begin
                ox  = xa ? hwo - adxo : hwo + asxo - atdxo;
                oy  = ya ? hho - adyo : hho + asyo - atdyo;
                dxs = xa ? i_item.dx : i_item.tdx;
                dys = ya ? i_item.dy : i_item.tdy;
            end
            default: begin
                ox = '0;
                oy = '0;
            end
        endcase
        mx0   = 32'(adxo - hwo);
        my0   = 32'(adyo - hho);
        halve = mx0[31] | my0[31];
        c.mode  = i_item.mode;
        c.hit0  = (i_item.mode != MODE_NONE) && (ox > 0) && (oy > 0);
        c.third = c.hit0 && (corner || (i_item.mode == MODE_TRI && hyp));
        c.ox    = ox;
        c.oy    = oy;
        c.dxs   = dxs;
        c.dys   = dys;
        c.bdx   = -i_item.dx;
        c.bdy   = -i_item.dy;
        c.negx  = i_item.dx < 0;
        c.negy  = i_item.dy < 0;
        c.hw    = i_item.hw;
        c.hh    = i_item.hh;
        c.sx    = i_item.sx;
        c.sy    = i_item.sy;
        c.hx    = i_item.hx;
        c.hy    = i_item.hy;
        c.mx    = halve ? mx0[31:1] : mx0[30:0];
        c.my    = halve ? my0[31:1] : my0[30:0];
        n_bc[0] = c;
    end

    always_comb begin : b12
        n_bc[1]     = r_bc[0];
        n_bc[1].sqx = r_bc[0].mx * r_bc[0].mx;
        n_bc[1].sqy = r_bc[0].my * r_bc[0].my;
        n_bc[1].pbx = r_bc[0].sx * r_bc[0].hx;
        n_bc[1].pby = r_bc[0].sy * r_bc[0].hy;
        n_bc[2]     = r_bc[1];
        n_bc[2].n   = 64'(r_bc[1].sqx) + 64'(r_bc[1].sqy);
        n_bc[2].bp  = (r_bc[1].mode == MODE_TRI)
                    ? OW'(f_tdiv14(64'(r_bc[1].pbx)) + f_tdiv14(64'(r_bc[1].pby)))
                    : OW'(r_bc[1].sx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NB; i++) begin
                r_bv[i] <= 1'b0;
            end
        end else begin
            r_bv[0] <= i_valid;
            for (int i = 1; i < NB; i++) begin
                r_bv[i] <= r_bv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NB; i++) begin
            r_bc[i] <= n_bc[i];
        end
    end

    acsp_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_bv[NB-1]),
        .i_ctx   (r_bc[NB-1]),
        .o_valid (nrm_v),
        .o_ctx   (nrm_c)
    );

    always_comb begin : post
        logic signed [15:0] qxs, qys;
        logic [47:0]        aw, ah;
        logic signed [63:0] dproj, absd;
        logic               lt;
        // signed unit axis
        qxs = 16'(nrm_c.qx);
        qys = 16'(nrm_c.qy);
        n_pc[0]    = nrm_c;
        n_pc[0].ux = (nrm_c.mode == MODE_CIRCLE) ? (nrm_c.negx ? -qxs : qxs) : nrm_c.hx;
        n_pc[0].uy = (nrm_c.mode == MODE_CIRCLE) ? (nrm_c.negy ? -qys : qys) : nrm_c.hy;
        // projections
        n_pc[1]     = r_pc[0];
        n_pc[1].pdx = r_pc[0].ux * r_pc[0].bdx;
        n_pc[1].pdy = r_pc[0].uy * r_pc[0].bdy;
        n_pc[1].phw = r_pc[0].ux * $signed({1'b0, r_pc[0].hw});
        n_pc[1].phh = r_pc[0].uy * $signed({1'b0, r_pc[0].hh});
        n_pc[2]      = r_pc[1];
        n_pc[2].dsum = 52'(r_pc[1].pdx) + 52'(r_pc[1].pdy);
        aw = (r_pc[1].phw < 0) ? -r_pc[1].phw : r_pc[1].phw;
        ah = (r_pc[1].phh < 0) ? -r_pc[1].phh : r_pc[1].phh;
        n_pc[2].ahw = aw[47:AXIS_SHIFT];
        n_pc[2].ahh = ah[47:AXIS_SHIFT];
        n_pc[3] = r_pc[2];
        dproj = f_tdiv14(64'(r_pc[2].dsum));
        absd = (dproj < 0) ? -dproj : dproj;
        n_pc[3].adist = OW'(absd);
        n_pc[3].apbp  = OW'(r_pc[2].ahw) + OW'(r_pc[2].ahh) + r_pc[2].bp;
        n_pc[4]    = r_pc[3];
        n_pc[4].ot = r_pc[3].apbp - r_pc[3].adist;
        // axis choice
        n_pc[5]      = r_pc[4];
        n_pc[5].hit  = r_pc[4].third ? (r_pc[4].ot > 0) : r_pc[4].hit0;
        lt           = r_pc[4].ox < r_pc[4].oy;
        n_pc[5].use3 = r_pc[4].third
                     && !(lt ? (r_pc[4].ox < r_pc[4].ot) : (r_pc[4].oy < r_pc[4].ot));
        n_pc[5].ptx  = r_pc[4].ux * r_pc[4].ot;
        n_pc[5].pty  = r_pc[4].uy * r_pc[4].ot;
        n_pc[5].pxs  = !lt ? '0 : ((r_pc[4].dxs > 0) ? r_pc[4].ox : -r_pc[4].ox);
        n_pc[5].pys  = lt ? '0 : ((r_pc[4].dys > 0) ? r_pc[4].oy : -r_pc[4].oy);
        n_out.hit = r_pc[5].hit;
        if (!r_pc[5].hit) begin
            n_out.push_x = '0;
            n_out.push_y = '0;
        end else if (r_pc[5].use3) begin
            n_out.push_x = f_sat32(f_tdiv14(64'(r_pc[5].ptx)));
            n_out.push_y = f_sat32(f_tdiv14(64'(r_pc[5].pty)));
        end else begin
            n_out.push_x = f_sat32(64'(r_pc[5].pxs));
            n_out.push_y = f_sat32(64'(r_pc[5].pys));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NP; i++) begin
                r_pv[i] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            r_pv[0] <= nrm_v;
            for (int i = 1; i < NP; i++) begin
                r_pv[i] <= r_pv[i-1];
            end
            r_ov <= r_pv[NP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NP; i++) begin
            r_pc[i] <= n_pc[i];
        end
        r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_res   = r_out;

endmodule

`default_nettype wire

FILE: rtl/aabb_shape_collision_push.sv
// Narrow-phase pair tester: axis-aligned box against box, circle or right-triangle tile.
// Top level; depends on acsp_pkg, acsp_front, acsp_fifo, acsp_back.
//
// Input side is a queue: present a test on i_item with push; it is taken on a
// clock edge where push is high and full is low. Result side is a queue too:
// while empty is low the oldest result sits on o_res; pop takes it.
// One test per cycle is taken while full is low, and one result per cycle is
// delivered while empty is low and pop is high, in order. The back end pipeline
// has 32 square-root stages and 15 divider stages plus projection and selection
// stages; every test goes through the same path.
// The back end issues only while results in flight plus waiting stay below
// OUT_DEPTH; when pop stays low, the result queue fills, issue stops, the
// front queue fills and full rises. Nothing is dropped.
// Reset (synchronous, active low) empties every queue and the pipeline; no
// clearing pass is needed.
`default_nettype none

module aabb_shape_collision_push #(
    parameter int MID_DEPTH = acsp_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = acsp_pkg::OUT_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  acsp_pkg::t_in  i_item,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output acsp_pkg::t_out o_res
);
    import acsp_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic          fr_push, mid_full, mid_empty, issue;
    t_mid          fr_item, mid_item;
    logic          bk_v, out_full, opop;
    t_out          bk_res;
    logic [CW-1:0] r_cred, n_cred;

    acsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_qfull (mid_full),
        .o_full  (full),
        .o_qpush (fr_push),
        .o_qitem (fr_item)
    );

    acsp_fifo #(
        .WIDTH ($bits(t_mid)),
        .DEPTH (MID_DEPTH)
    ) u_midq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_item),
        .i_pop   (issue),
        .o_full  (mid_full),
        .o_empty (mid_empty),
        .o_data  (mid_item)
    );

    assign issue  = ~mid_empty & (r_cred < CW'(OUT_DEPTH));
    assign opop   = pop & ~empty;
    assign n_cred = r_cred + CW'(issue) - CW'(opop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
        end else begin
            r_cred <= n_cred;
        end
    end

    acsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_item  (mid_item),
        .o_valid (bk_v),
        .o_res   (bk_res)
    );

    acsp_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_v),
        .i_data  (bk_res),
        .i_pop   (pop),
        .o_full  (out_full),
        .o_empty (empty),
        .o_data  (o_res)
    );

    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= CW'(OUT_DEPTH))
        else $error("result credit count above limit");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_v |-> !out_full)
        else $error("back end result with no room in result queue");

    a_mid_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_push |-> !mid_full)
        else $error("front word pushed into full queue");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_res.hit) |-> (o_res.push_x == 0 && o_res.push_y == 0))
        else $error("push vector nonzero on a miss");

endmodule

`default_nettype wire
